FILE: rtl/core/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal block
// Fixed-point widths of every pipeline segment and the item structs.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // input coordinates, signed Q8.16
  localparam int COORD_WIDTH = 24;
  // output components, signed Q1.22
  localparam int OUT_WIDTH   = 24;

  // exact edge, product and cross widths
  localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int BLEN_WIDTH  = $clog2(CROSS_WIDTH + 1);

  // block scaling and length
  localparam int SCALE_BITS  = 24;
  localparam int SQ_WIDTH    = 2 * SCALE_BITS;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;
  localparam int RAD_SHIFT   = 12;
  localparam int RAD_WIDTH   = SUM_WIDTH + RAD_SHIFT;
  localparam int ROOT_BITS   = RAD_WIDTH / 2;
  localparam int SREM_WIDTH  = ROOT_BITS + 1;

  // component division
  localparam int FRAC_SHIFT  = 28;
  localparam int NUM_WIDTH   = SCALE_BITS + FRAC_SHIFT + 1;
  localparam int QUO_BITS    = 23;
  localparam int DREM_WIDTH  = ROOT_BITS + 1;
  localparam logic [QUO_BITS-1:0] ONE_Q22 = QUO_BITS'(1) << 22;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] n_x;
    logic signed [OUT_WIDTH-1:0] n_y;
    logic signed [OUT_WIDTH-1:0] n_z;
    logic                        degenerate;
  } out_t;

  // scaled magnitudes and signs riding along the length pipeline
  typedef struct packed {
    logic [2:0][SCALE_BITS-1:0] m;
    logic [2:0]                 neg;
    logic                       deg;
  } carry_t;

  // one square root step
  typedef struct packed {
    logic [SREM_WIDTH-1:0] rem;
    logic [ROOT_BITS-1:0]  root;
    logic [RAD_WIDTH-1:0]  rad;
    carry_t                cry;
  } root_t;

  // one division step, three components side by side
  typedef struct packed {
    logic [2:0][DREM_WIDTH-1:0] rem;
    logic [2:0][QUO_BITS-1:0]   low;
    logic [2:0][QUO_BITS-1:0]   quo;
    logic [ROOT_BITS-1:0]       len;
    logic [2:0]                 neg;
    logic                       deg;
  } div_t;

endpackage

FILE: rtl/core/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal: unit normal of a triangle in fixed point
// Cross product of the edges a-b and b-c, block scaling, square root and division.
// ----------------------------------------------------------------------------
// Usage
//   The input channel takes one triangle per item: three vertices with
//   signed Q8.16 coordinates. The output channel gives one item per
//   triangle: the unit normal as three signed Q1.22 components and a flag
//   that is set, with a zero vector, when the cross product is zero.
//   Both channels use valid and stall; an item moves when valid is high
//   and stall is low.
//   Throughput is one item per cycle while the receiver does not stall.
//   From input acceptance to output valid an item passes the stages of
//   edges, products, cross, magnitudes, bit length, scaling, squares, sum,
//   the bit-per-stage square root, a register that sets up the numerators,
//   the bit-per-stage dividers and one output register.
//   Reset clears all stage valid bits; the pipeline then holds no items.
//   When the receiver stalls, the last stage holds its item and stages
//   behind it keep filling bubbles; input stall rises only once every
//   stage holds an item.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tfn_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tfn_pkg::out_t out_item_o
);

  localparam int ST_EDGE  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_CROSS = 2;
  localparam int ST_MAG   = 3;
  localparam int ST_LEN   = 4;
  localparam int ST_NORM  = 5;
  localparam int ST_SQR   = 6;
  localparam int ST_SUM   = 7;
  localparam int ST_ROOT0 = 8;
  localparam int ST_DPREP = ST_ROOT0 + tfn_pkg::ROOT_BITS;
  localparam int ST_DIV0  = ST_DPREP + 1;
  localparam int ST_OUT   = ST_DIV0 + tfn_pkg::QUO_BITS;
  localparam int NSTAGE   = ST_OUT + 1;

  localparam int CW = tfn_pkg::CROSS_WIDTH;

  // bit length of a magnitude
  function automatic logic [tfn_pkg::BLEN_WIDTH-1:0] bit_len(input logic [CW-1:0] v);
    logic [tfn_pkg::BLEN_WIDTH-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) n = tfn_pkg::BLEN_WIDTH'(i + 1);
    end
    return n;
  endfunction

  // stage valid bits and load enables
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o = !en[ST_EDGE];

  // vertex arrays
  logic signed [tfn_pkg::COORD_WIDTH-1:0] va[3], vb[3], vc[3];
  assign va[0] = in_item_i.a_x;
  assign va[1] = in_item_i.a_y;
  assign va[2] = in_item_i.a_z;
  assign vb[0] = in_item_i.b_x;
  assign vb[1] = in_item_i.b_y;
  assign vb[2] = in_item_i.b_z;
  assign vc[0] = in_item_i.c_x;
  assign vc[1] = in_item_i.c_y;
  assign vc[2] = in_item_i.c_z;

  // edges
  logic signed [tfn_pkg::EDGE_WIDTH-1:0] e1_q[3], e2_q[3];
  always_ff @(posedge clk_i) begin
    if (en[ST_EDGE]) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= tfn_pkg::EDGE_WIDTH'(va[i]) - tfn_pkg::EDGE_WIDTH'(vb[i]);
        e2_q[i] <= tfn_pkg::EDGE_WIDTH'(vb[i]) - tfn_pkg::EDGE_WIDTH'(vc[i]);
      end
    end
  end

  // cross product partial products
  logic signed [tfn_pkg::PROD_WIDTH-1:0] pa_q[3], pb_q[3];
  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      pa_q[0] <= e2_q[1] * e1_q[2];
      pb_q[0] <= e2_q[2] * e1_q[1];
      pa_q[1] <= e2_q[2] * e1_q[0];
      pb_q[1] <= e2_q[0] * e1_q[2];
      pa_q[2] <= e2_q[0] * e1_q[1];
      pb_q[2] <= e2_q[1] * e1_q[0];
    end
  end

  // cross components
  logic signed [CW-1:0] c_q[3];
  always_ff @(posedge clk_i) begin
    if (en[ST_CROSS]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
      end
    end
  end

  // magnitudes and signs
  logic [CW-1:0] mag_q[3];
  logic [2:0]    neg_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_MAG]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= c_q[i][CW-1];
        mag_q[i] <= c_q[i][CW-1] ? CW'(-c_q[i]) : CW'(c_q[i]);
      end
    end
  end

  // bit length of the largest magnitude
  logic [CW-1:0]                  mag2_q[3];
  logic [2:0]                     neg2_q;
  logic [tfn_pkg::BLEN_WIDTH-1:0] blen_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_LEN]) begin
      for (int i = 0; i < 3; i++) mag2_q[i] <= mag_q[i];
      neg2_q <= neg_q;
      blen_q <= bit_len(mag_q[0] | mag_q[1] | mag_q[2]);
    end
  end

  // block scaling: largest magnitude into [2^23, 2^24)
  tfn_pkg::carry_t cry_norm_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_NORM]) begin
      for (int i = 0; i < 3; i++) begin
        cry_norm_q.m[i] <= tfn_pkg::SCALE_BITS'(
          {mag2_q[i], {tfn_pkg::SCALE_BITS{1'b0}}} >> blen_q);
      end
      cry_norm_q.neg <= neg2_q;
      cry_norm_q.deg <= (blen_q == '0);
    end
  end

  // squares
  logic [tfn_pkg::SQ_WIDTH-1:0] sq_q[3];
  tfn_pkg::carry_t              cry_sqr_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_SQR]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= tfn_pkg::SQ_WIDTH'(cry_norm_q.m[i]) * tfn_pkg::SQ_WIDTH'(cry_norm_q.m[i]);
      end
      cry_sqr_q <= cry_norm_q;
    end
  end

  // sum of squares, scaled for the root
  logic [tfn_pkg::SUM_WIDTH-1:0] sum_d;
  logic [tfn_pkg::RAD_WIDTH-1:0] rad_q;
  tfn_pkg::carry_t               cry_sum_q;
  assign sum_d = tfn_pkg::SUM_WIDTH'(sq_q[0]) + tfn_pkg::SUM_WIDTH'(sq_q[1])
               + tfn_pkg::SUM_WIDTH'(sq_q[2]);
  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      rad_q     <= {sum_d, {tfn_pkg::RAD_SHIFT{1'b0}}};
      cry_sum_q <= cry_sqr_q;
    end
  end

  // square root, one result bit per stage
  tfn_pkg::root_t rt_q[tfn_pkg::ROOT_BITS];
  for (genvar j = 0; j < tfn_pkg::ROOT_BITS; j++) begin : g_root
    tfn_pkg::root_t                src, nxt;
    logic [tfn_pkg::SREM_WIDTH+1:0] cur, trial;
    if (j == 0) begin : g_first
      always_comb begin
        src     = '0;
        src.rad = rad_q;
        src.cry = cry_sum_q;
      end
    end else begin : g_next
      assign src = rt_q[j-1];
    end
    assign cur   = {src.rem, src.rad[tfn_pkg::RAD_WIDTH-1 -: 2]};
    assign trial = (tfn_pkg::SREM_WIDTH + 2)'({src.root, 2'b01});
    always_comb begin
      nxt     = src;
      nxt.rad = src.rad << 2;
      if (cur >= trial) begin
        nxt.rem  = tfn_pkg::SREM_WIDTH'(cur - trial);
        nxt.root = {src.root[tfn_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        nxt.rem  = tfn_pkg::SREM_WIDTH'(cur);
        nxt.root = {src.root[tfn_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[ST_ROOT0+j]) rt_q[j] <= nxt;
    end
  end

  // numerators with half-length rounding
  tfn_pkg::root_t               rt_last;
  logic [tfn_pkg::NUM_WIDTH-1:0] num[3];
  tfn_pkg::div_t                dp_d, dp_q;
  assign rt_last = rt_q[tfn_pkg::ROOT_BITS-1];
  always_comb begin
    dp_d     = '0;
    dp_d.len = rt_last.root;
    dp_d.neg = rt_last.cry.neg;
    dp_d.deg = rt_last.cry.deg;
    for (int i = 0; i < 3; i++) begin
      num[i] = (tfn_pkg::NUM_WIDTH'(rt_last.cry.m[i]) << tfn_pkg::FRAC_SHIFT)
             + tfn_pkg::NUM_WIDTH'(rt_last.root >> 1);
      dp_d.rem[i] = tfn_pkg::DREM_WIDTH'(num[i] >> tfn_pkg::QUO_BITS);
      dp_d.low[i] = num[i][tfn_pkg::QUO_BITS-1:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[ST_DPREP]) dp_q <= dp_d;
  end

  // dividers, one quotient bit per stage
  tfn_pkg::div_t dv_q[tfn_pkg::QUO_BITS];
  for (genvar k = 0; k < tfn_pkg::QUO_BITS; k++) begin : g_div
    tfn_pkg::div_t                  src, nxt;
    logic [tfn_pkg::DREM_WIDTH:0]   cur[3];
    if (k == 0) begin : g_first
      assign src = dp_q;
    end else begin : g_next
      assign src = dv_q[k-1];
    end
    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        cur[i]     = {src.rem[i], src.low[i][tfn_pkg::QUO_BITS-1]};
        nxt.low[i] = src.low[i] << 1;
        if (cur[i] >= (tfn_pkg::DREM_WIDTH + 1)'(src.len)) begin
          nxt.rem[i] = tfn_pkg::DREM_WIDTH'(cur[i] - (tfn_pkg::DREM_WIDTH + 1)'(src.len));
          nxt.quo[i] = {src.quo[i][tfn_pkg::QUO_BITS-2:0], 1'b1};
        end else begin
          nxt.rem[i] = tfn_pkg::DREM_WIDTH'(cur[i]);
          nxt.quo[i] = {src.quo[i][tfn_pkg::QUO_BITS-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0+k]) dv_q[k] <= nxt;
    end
  end

  // saturate, sign and degenerate override
  tfn_pkg::div_t                       dv_last;
  logic [tfn_pkg::QUO_BITS-1:0]        sat[3];
  logic signed [tfn_pkg::OUT_WIDTH-1:0] comp[3];
  tfn_pkg::out_t                       out_d, out_q;
  assign dv_last = dv_q[tfn_pkg::QUO_BITS-1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i]  = (dv_last.quo[i] > tfn_pkg::ONE_Q22) ? tfn_pkg::ONE_Q22 : dv_last.quo[i];
      comp[i] = dv_last.neg[i] ? -tfn_pkg::OUT_WIDTH'(sat[i]) : tfn_pkg::OUT_WIDTH'(sat[i]);
      if (dv_last.deg) comp[i] = '0;
    end
    out_d.n_x        = comp[0];
    out_d.n_y        = comp[1];
    out_d.n_z        = comp[2];
    out_d.degenerate = dv_last.deg;
  end
  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) out_q <= out_d;
  end

  assign out_valid_o = v_q[ST_OUT];
  assign out_item_o  = out_q;

endmodule

FILE: sim/triangle_face_normal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_tb: self-checking bench for the face normal pipeline
// Feeds directed and random triangles, predicts each unit normal with exact
// integer math and compares every output item field by field, in order.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;

  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [tfn_pkg::COORD_WIDTH-1:0] CMAX =
    {1'b0, {(tfn_pkg::COORD_WIDTH-1){1'b1}}};
  localparam logic [tfn_pkg::COORD_WIDTH-1:0] CMIN =
    {1'b1, {(tfn_pkg::COORD_WIDTH-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tfn_pkg::in_t  in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tfn_pkg::out_t out_item_o;

  tfn_pkg::in_t  triangles_q[$];
  tfn_pkg::out_t normals_q[$];
  int   sent_cnt = 0;
  int   recv_cnt = 0;
  int   cycle_cnt = 0;
  int   fail_cnt = 0;

  triangle_face_normal dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // exact unit normal of one triangle
  function automatic tfn_pkg::out_t unit_normal(tfn_pkg::in_t t);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint e1[3], e2[3], cr[3];
    logic [63:0] mg[3], m[3], rad, root, bit_w, num, n;
    logic [2:0] neg;
    int bl;
    tfn_pkg::out_t r;
    ax = t.a_x; ay = t.a_y; az = t.a_z;
    bx = t.b_x; by = t.b_y; bz = t.b_z;
    cx = t.c_x; cy = t.c_y; cz = t.c_z;
    e1[0] = ax - bx; e1[1] = ay - by; e1[2] = az - bz;
    e2[0] = bx - cx; e2[1] = by - cy; e2[2] = bz - cz;
    cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
    cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
    cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mg[i] = neg[i] ? -cr[i] : cr[i];
      for (int k = 0; k < 64; k++) if (mg[i][k] && k + 1 > bl) bl = k + 1;
    end
    r = '0;
    if (bl == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // common block scaling into [2^23, 2^24)
    for (int i = 0; i < 3; i++)
      m[i] = (bl > tfn_pkg::SCALE_BITS) ? mg[i] >> (bl - tfn_pkg::SCALE_BITS)
                                        : mg[i] << (tfn_pkg::SCALE_BITS - bl);
    rad = (m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) << 12;
    // integer square root
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rad) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rad >= root + bit_w) begin
        rad = rad - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else root = root >> 1;
      bit_w = bit_w >> 2;
    end
    for (int i = 0; i < 3; i++) begin
      num = (m[i] << 28) + (root >> 1);
      n = num / root;
      if (n > 64'd4194304) n = 64'd4194304;
      if (neg[i]) n = -n;
      if (i == 0) r.n_x = n[23:0];
      else if (i == 1) r.n_y = n[23:0];
      else r.n_z = n[23:0];
    end
    return r;
  endfunction

  // idle percentage per phase, by item count
  function automatic bit roll_idle(int cnt, bit sender);
    int ph;
    int pct;
    ph = (cnt / PHASE_ITEMS) % 4;
    case (ph)
      1: pct = sender ? 46 : 0;
      2: pct = sender ? 0 : 46;
      3: pct = 33;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [tfn_pkg::COORD_WIDTH-1:0] rand_coord(int kind);
    logic [tfn_pkg::COORD_WIDTH-1:0] pick[5];
    pick = '{CMAX, CMIN, '0, '1, tfn_pkg::COORD_WIDTH'(1)};
    case (kind)
      1: return tfn_pkg::COORD_WIDTH'($signed($urandom_range(512)) - 256);
      2: return pick[$urandom_range(4)];
      default: return tfn_pkg::COORD_WIDTH'($urandom);
    endcase
  endfunction

  task automatic add_triangle(logic [tfn_pkg::COORD_WIDTH-1:0] ax, ay, az,
                              bx, by, bz, cx, cy, cz);
    tfn_pkg::in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    triangles_q = {triangles_q, t};
  endtask

  // driver: accepted items are predicted, then the next one is offered
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        normals_q = {normals_q, unit_normal(in_item_i)};
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (triangles_q.size() > 0 && !roll_idle(sent_cnt, 1'b1)) begin
          in_item_i <= triangles_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    tfn_pkg::out_t exp_n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        recv_cnt <= recv_cnt + 1;
        if (normals_q.size() == 0) begin
          $error("unexpected output item %h", out_item_o);
          fail_cnt++;
        end else begin
          exp_n = normals_q.pop_front();
          if (out_item_o.n_x !== exp_n.n_x) begin
            $error("n_x expected %0d actual %0d", exp_n.n_x, out_item_o.n_x);
            fail_cnt++;
          end
          if (out_item_o.n_y !== exp_n.n_y) begin
            $error("n_y expected %0d actual %0d", exp_n.n_y, out_item_o.n_y);
            fail_cnt++;
          end
          if (out_item_o.n_z !== exp_n.n_z) begin
            $error("n_z expected %0d actual %0d", exp_n.n_z, out_item_o.n_z);
            fail_cnt++;
          end
          if (out_item_o.degenerate !== exp_n.degenerate) begin
            $error("degenerate expected %0b actual %0b", exp_n.degenerate,
                   out_item_o.degenerate);
            fail_cnt++;
          end
        end
      end
      out_stall_i <= roll_idle(recv_cnt, 1'b0);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    logic [tfn_pkg::COORD_WIDTH-1:0] v[9];
    // directed: degenerate, extremes, axis planes, collinear
    add_triangle('0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_triangle(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, '0, '0, '0);
    add_triangle(CMAX, CMIN, '0, CMIN, CMAX, '0, '0, '0, CMAX);
    add_triangle(CMIN, '0, '0, '0, CMIN, '0, '0, '0, CMIN);
    add_triangle(CMAX, '0, '0, '0, CMAX, '0, '0, '0, CMAX);
    add_triangle(CMAX, CMAX, '0, CMIN, CMAX, '0, CMIN, CMIN, '0);
    add_triangle('0, '0, '0, 24'd65536, '0, '0, '0, 24'd65536, '0);
    add_triangle('0, '0, '0, '0, 24'd65536, '0, '0, '0, 24'd65536);
    add_triangle('0, '0, '0, '0, '0, 24'd65536, 24'd65536, '0, '0);
    add_triangle('0, '0, '0, 24'd1, '0, '0, '0, 24'd1, '0);
    add_triangle(24'd1, 24'd2, 24'd3, 24'd2, 24'd4, 24'd6, 24'd3, 24'd6, 24'd9);
    add_triangle('1, '1, '1, '1, '1, '1, '1, '1, '1);
    add_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, '0, '0, '0);
    add_triangle(24'd5, '0, '0, 24'd5, '0, '0, '0, 24'd7, '0);
    add_triangle(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX);
    add_triangle(24'd1, '0, '0, '0, '0, '0, '0, 24'd1, 24'd1);
    // random triangles, with a share of small, extreme and repeated vertices
    repeat (900) begin
      kind = $urandom_range(99);
      for (int i = 0; i < 9; i++)
        v[i] = rand_coord(kind < 65 ? 0 : kind < 80 ? 1 : kind < 90 ? 2 : 0);
      if (kind >= 90) begin
        for (int i = 0; i < 3; i++) v[6 + i] = v[$urandom_range(1) * 3 + i];
      end
      add_triangle(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // drain
    while (triangles_q.size() > 0 || in_valid_i || normals_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
